// ===== hw/rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Types and codes shared by the double-ended queue and its testbench.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Command codes.
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_SIZE       = 3'd4;

  // Status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic [4:0]         count;
    logic [1:0]         status;
    logic               is_empty;
    logic               is_size_reply;
    logic               last;
  } rsp_t;

endpackage

// ===== hw/rtl/deq_mem.sv =====
// ----------------------------------------------------------------------------
// deq_mem
// Word store of the queue: one write port and one registered read port.
// ----------------------------------------------------------------------------
module deq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/double_ended_queue_with_dump_top.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_with_dump_top
// Bounded double-ended queue of signed words that dumps its contents after
// every push or pop.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// It pushes at the front or back, pops from the front or back, or asks for
// the number of words held. Results leave on rsp, each one valid for exactly
// one cycle while strobe is high; the receiver cannot hold them off.
// After a push or pop that leaves n words held, the words are read from the
// store one per cycle, front first, and appear on rsp in the cycle after each
// read, the final one marked by last. The store's single read port sets the
// pace, and busy stays high until the last of the n words has been read.
// A request that leaves the queue empty, a pop on an empty queue and a size
// query give one result in the cycle after acceptance and keep busy low, so
// they may follow each other every cycle. Unused command codes are ignored.
// A push on a full queue is dropped and flagged on every result of its dump.
// Reset empties the queue at once; the store contents are left as they are,
// since no word is read before it has been written.
// ----------------------------------------------------------------------------
module double_ended_queue_with_dump_top #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  deq_pkg::req_t req,
  output logic          strobe,
  output deq_pkg::rsp_t rsp
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic          state;
  logic [IW-1:0] front;
  logic [CW-1:0] count;
  logic [1:0]    status_q;
  logic [IW-1:0] rd_idx;

  // Output stage registers.
  logic          o_vld;
  logic          o_word;
  logic          o_last;
  logic          o_empty;
  logic          o_size;
  logic [1:0]    o_status;
  logic [4:0]    o_count;

  logic          accept;
  logic [IW-1:0] front_next;
  logic [CW-1:0] count_next;
  logic [1:0]    status_next;
  logic          go_dump;
  logic          direct;
  logic          direct_size;
  logic          we;
  logic [IW-1:0] waddr;
  logic [SW-1:0] back_sum;
  logic [IW-1:0] back_pos;
  logic [SW-1:0] rd_sum;
  logic [IW-1:0] raddr;
  logic          rd_last;
  logic          re;
  logic [31:0]   rdata;

  assign accept = start && !busy;
  assign busy   = (state == ST_DUMP);

  // Slot just past the back word: front + count, wrapped once.
  assign back_sum = SW'(front) + SW'(count);
  assign back_pos = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);

  // Read address of the current dump position.
  assign rd_sum  = SW'(front) + SW'(rd_idx);
  assign raddr   = (rd_sum >= SW'(DEPTH)) ? IW'(rd_sum - SW'(DEPTH)) : IW'(rd_sum);
  assign rd_last = (rd_idx == IW'(count - 1'b1));
  assign re      = (state == ST_DUMP);

  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = deq_pkg::STATUS_OK;
    go_dump     = 1'b0;
    direct      = 1'b0;
    direct_size = 1'b0;
    we          = 1'b0;
    waddr       = back_pos;
    case (req.cmd)
      deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
        // A push always leaves at least one word, so the dump is read out.
        go_dump = 1'b1;
        if (count >= CW'(DEPTH)) begin
          status_next = deq_pkg::STATUS_PUSH_FULL;
        end else begin
          we         = 1'b1;
          count_next = count + 1'b1;
          if (req.cmd == deq_pkg::CMD_PUSH_FRONT) begin
            front_next = (front == '0) ? IW'(DEPTH - 1) : front - 1'b1;
            waddr      = front_next;
          end
        end
      end
      deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
        if (count == '0) begin
          status_next = deq_pkg::STATUS_POP_EMPTY;
          direct      = 1'b1;
        end else begin
          count_next = count - 1'b1;
          if (req.cmd == deq_pkg::CMD_POP_FRONT) begin
            front_next = (front == IW'(DEPTH - 1)) ? '0 : front + 1'b1;
          end
          if (count_next == '0) begin
            direct = 1'b1;
          end else begin
            go_dump = 1'b1;
          end
        end
      end
      deq_pkg::CMD_SIZE: begin
        direct      = 1'b1;
        direct_size = 1'b1;
      end
      default: begin
      end
    endcase
  end

  deq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (32)
  ) u_mem (
    .clk   (clk),
    .we    (accept && we),
    .waddr (waddr),
    .wdata (req.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      count <= '0;
      o_vld <= 1'b0;
    end else begin
      o_vld <= 1'b0;
      if (accept) begin
        front    <= front_next;
        count    <= count_next;
        status_q <= status_next;
        if (go_dump) begin
          state  <= ST_DUMP;
          rd_idx <= '0;
        end else if (direct) begin
          // Single result with no stored word behind it.
          o_vld    <= 1'b1;
          o_word   <= 1'b0;
          o_last   <= 1'b1;
          o_empty  <= (count_next == '0);
          o_size   <= direct_size;
          o_status <= status_next;
          o_count  <= 5'(count_next);
        end
      end else if (state == ST_DUMP) begin
        // The word read at this edge is shown in the next cycle.
        o_vld    <= 1'b1;
        o_word   <= 1'b1;
        o_last   <= rd_last;
        o_empty  <= 1'b0;
        o_size   <= 1'b0;
        o_status <= status_q;
        o_count  <= 5'(count);
        rd_idx   <= rd_idx + 1'b1;
        if (rd_last) begin
          state <= ST_IDLE;
        end
      end
    end
  end

  assign strobe            = o_vld;
  assign rsp.element       = o_word ? rdata : '0;
  assign rsp.count         = o_count;
  assign rsp.status        = o_status;
  assign rsp.is_empty      = o_empty;
  assign rsp.is_size_reply = o_size;
  assign rsp.last          = o_last;

  // The number of words held never goes beyond the store's depth.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("held count exceeds depth");

  // Every read issued during a dump is shown as a result in the next cycle.
  a_dump_shows : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |=> (strobe && !rsp.is_empty && !rsp.is_size_reply))
    else $error("dump read not delivered");

  // A run of results has no gaps: a result that is not last is followed by one.
  a_run_contiguous : assert property (@(posedge clk) disable iff (rst)
    (strobe && !rsp.last) |=> strobe)
    else $error("gap in result run");

  // A size query is answered in the next cycle with a single marked result.
  a_size_reply : assert property (@(posedge clk) disable iff (rst)
    (accept && (req.cmd == deq_pkg::CMD_SIZE))
      |=> (strobe && rsp.is_size_reply && rsp.last))
    else $error("size query not answered");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the bounded double-ended queue with dump.
// ----------------------------------------------------------------------------
// Requests are taken from a backlog and offered on the start/busy handshake.
// Each accepted request is applied to a local copy of the deque. That copy
// predicts the run of results the block should produce. The monitor checks
// every strobed result, field by field, against the oldest prediction still
// waiting. A directed opening covers the corner cases. Biased random traffic
// then fills and drains the deque many times under several sender idle
// rates.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int RANDOM_REQS = 330;
  localparam int CYCLE_LIMIT = 300000;

  // A pending request together with the chance, in percent, that the
  // sender sits idle for a cycle instead of offering it.
  typedef struct {
    deq_pkg::req_t payload;
    int            gap_pct;
  } backlog_item_t;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  deq_pkg::req_t  req;
  logic           strobe;
  deq_pkg::rsp_t  rsp;

  backlog_item_t      cmd_backlog_q[$];
  deq_pkg::rsp_t      predicted_dump_q[$];

  // Local image of the deque: the word store, the front position and the
  // number of words held.
  logic signed [31:0] deque_words[DEPTH];
  int                 deque_front;
  int                 deque_fill;

  bit                 failed;
  int                 cycle_count;

  double_ended_queue_with_dump_top #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .strobe(strobe),
    .rsp   (rsp)
  );

  // The clock runs at a 2 ns period.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Expected run for a push or pop: every word held, front first, or a
  // single empty marker when nothing is held. The status repeats on every
  // result of the run.
  task automatic predict_dump(logic [1:0] status);
    deq_pkg::rsp_t r;
    if (deque_fill == 0) begin
      r               = '0;
      r.status        = status;
      r.is_empty      = 1'b1;
      r.last          = 1'b1;
      predicted_dump_q = {predicted_dump_q, r};
    end else begin
      for (int i = 0; i < deque_fill; i++) begin
        r          = '0;
        r.element  = deque_words[(deque_front + i) % DEPTH];
        r.count    = 5'(deque_fill);
        r.status   = status;
        r.last     = (i == deque_fill - 1);
        predicted_dump_q = {predicted_dump_q, r};
      end
    end
  endtask

  // Applies one accepted request to the local deque and queues the results
  // it should cause.
  task automatic apply_deque_cmd(deq_pkg::req_t r);
    deq_pkg::rsp_t reply;
    case (r.cmd)
      deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
        if (deque_fill >= DEPTH) begin
          // Full: the word is dropped but the contents are still dumped.
          predict_dump(deq_pkg::STATUS_PUSH_FULL);
        end else begin
          if (r.cmd == deq_pkg::CMD_PUSH_FRONT) begin
            deque_front              = (deque_front + DEPTH - 1) % DEPTH;
            deque_words[deque_front] = r.value;
          end else begin
            deque_words[(deque_front + deque_fill) % DEPTH] = r.value;
          end
          deque_fill++;
          predict_dump(deq_pkg::STATUS_OK);
        end
      end
      deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
        if (deque_fill == 0) begin
          // A pop on an empty deque changes nothing and is flagged.
          predict_dump(deq_pkg::STATUS_POP_EMPTY);
        end else begin
          if (r.cmd == deq_pkg::CMD_POP_FRONT) begin
            deque_front = (deque_front + 1) % DEPTH;
          end
          deque_fill--;
          predict_dump(deq_pkg::STATUS_OK);
        end
      end
      deq_pkg::CMD_SIZE: begin
        reply               = '0;
        reply.count         = 5'(deque_fill);
        reply.status        = deq_pkg::STATUS_OK;
        reply.is_empty      = (deque_fill == 0);
        reply.is_size_reply = 1'b1;
        reply.last          = 1'b1;
        predicted_dump_q = {predicted_dump_q, reply};
      end
      default: begin
        // The unused codes are ignored by the block and give no result.
      end
    endcase
  endtask

  task automatic compare_rsp(deq_pkg::rsp_t want, deq_pkg::rsp_t got);
    if (got.element !== want.element) begin
      $error("element: expected %0d, got %0d", want.element, got.element);
      failed = 1'b1;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, got.count);
      failed = 1'b1;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      failed = 1'b1;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
      failed = 1'b1;
    end
    if (got.is_size_reply !== want.is_size_reply) begin
      $error("is_size_reply: expected %0b, got %0b",
             want.is_size_reply, got.is_size_reply);
      failed = 1'b1;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      failed = 1'b1;
    end
  endtask

  task automatic queue_cmd(logic [2:0] cmd, logic signed [31:0] value, int gap_pct);
    backlog_item_t item;
    item.payload.cmd   = cmd;
    item.payload.value = value;
    item.gap_pct       = gap_pct;
    cmd_backlog_q = {cmd_backlog_q, item};
  endtask

  // Random word, with the extremes and the all-zero and all-one patterns
  // turning up more often than chance alone would allow.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return 32'shffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Builds the whole request stream before reset is released.
  initial begin : build_stimulus
    int         counted;
    int         mode;
    int         mode_left;
    int         gap_pct;
    int         roll;
    logic [2:0] cmd;

    // Directed opening. The empty deque is probed first: a size query and
    // a pop from each end, both of which must leave it untouched.
    queue_cmd(deq_pkg::CMD_SIZE,      32'sd0, 0);
    queue_cmd(deq_pkg::CMD_POP_FRONT, 32'sd0, 0);
    queue_cmd(deq_pkg::CMD_POP_BACK,  32'sd0, 0);
    // Popping the only word from either end must leave an empty deque.
    queue_cmd(deq_pkg::CMD_PUSH_BACK,  32'sd7, 0);
    queue_cmd(deq_pkg::CMD_POP_BACK,   32'sd0, 0);
    queue_cmd(deq_pkg::CMD_PUSH_FRONT, -32'sd5, 0);
    queue_cmd(deq_pkg::CMD_POP_FRONT,  32'sd0, 0);
    // The unused command codes must be ignored outright.
    queue_cmd(3'd5, 32'sh7fff_ffff, 0);
    queue_cmd(3'd6, 32'sh8000_0000, 0);
    queue_cmd(3'd7, 32'shffff_ffff, 0);
    // The most negative and most positive words, then fill to the brim
    // from both ends so that the store wraps round.
    queue_cmd(deq_pkg::CMD_PUSH_FRONT, 32'sh7fff_ffff, 0);
    queue_cmd(deq_pkg::CMD_PUSH_BACK,  32'sh8000_0000, 0);
    for (int i = 0; i < DEPTH - 2; i++) begin
      queue_cmd((i % 2 == 0) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK,
                pick_word(), 0);
    end
    // A push on a full deque, at either end, is dropped and flagged.
    queue_cmd(deq_pkg::CMD_PUSH_FRONT, 32'sh1234_5678, 0);
    queue_cmd(deq_pkg::CMD_PUSH_BACK,  -32'sd1, 0);
    queue_cmd(deq_pkg::CMD_SIZE,       32'sd0, 0);

    // Random part. The traffic swings between push-heavy, pop-heavy and
    // balanced spells so that the deque is filled and drained repeatedly.
    // The sender idle rate steps through the phases: none, 72 in a hundred,
    // none again, then 14 in a hundred. Ignored codes are sprinkled in but
    // are not counted.
    counted   = 0;
    mode      = 0;
    mode_left = 0;
    while (counted < RANDOM_REQS) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(2);
        mode_left = $urandom_range(40, 20);
      end
      mode_left--;
      case (counted * 4 / RANDOM_REQS)
        1:       gap_pct = 72;
        3:       gap_pct = 14;
        default: gap_pct = 0;
      endcase
      roll = $urandom_range(99);
      if (roll < 3) begin
        cmd = 3'($urandom_range(7, 5));
      end else begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          cmd = deq_pkg::CMD_SIZE;
        end else if ((mode == 0 && roll < 90) || (mode == 1 && roll < 20) ||
                     (mode == 2 && roll < 55)) begin
          cmd = $urandom_range(1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
        end else begin
          cmd = $urandom_range(1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
        end
        counted++;
      end
      queue_cmd(cmd, pick_word(), gap_pct);
    end
  end

  // Reset is held at the start and never again.
  initial begin
    rst    = 1'b1;
    start  = 1'b0;
    req    = '0;
    failed = 1'b0;
    deque_front = 0;
    deque_fill  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver. A request counts as taken at an edge where start is high and
  // busy is low; it is then applied to the local deque. start and req are
  // each assigned at most once per edge, so a request that follows straight
  // on keeps start high without a dip.
  always @(posedge clk) begin : drive_requests
    logic offering;
    if (rst) begin
      start <= 1'b0;
    end else begin
      offering = start;
      if (start && !busy) begin
        apply_deque_cmd(req);
        offering = 1'b0;
      end
      if (!offering) begin
        if (cmd_backlog_q.size() != 0 &&
            $urandom_range(99) >= cmd_backlog_q[0].gap_pct) begin
          req   <= cmd_backlog_q[0].payload;
          start <= 1'b1;
          cmd_backlog_q.delete(0);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every strobed result is matched with the oldest prediction;
  // a result with nothing waiting is a failure in its own right.
  always @(posedge clk) begin : watch_results
    deq_pkg::rsp_t want;
    if (!rst && strobe) begin
      if (predicted_dump_q.size() == 0) begin
        $error("unexpected result: element %0d count %0d status %0d",
               rsp.element, rsp.count, rsp.status);
        failed = 1'b1;
      end else begin
        want = predicted_dump_q[0];
        predicted_dump_q.delete(0);
        compare_rsp(want, rsp);
      end
    end
  end

  // Guard against a hung block: the slowest correct run is far shorter.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // End of test. Once every request has been taken and every predicted
  // result has arrived, a wait longer than the longest dump is allowed so
  // that any stray result still shows up before the verdict.
  initial begin : finish_run
    @(negedge clk);
    while (rst || cmd_backlog_q.size() != 0 || start) @(negedge clk);
    while (predicted_dump_q.size() != 0) @(negedge clk);
    repeat (DEPTH + 4) @(negedge clk);
    if (!failed && predicted_dump_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
